// ----- hdl/ppru_pkg.sv -----
// shared constants, types and constant tables of the partial permutation rank unit
package ppru_pkg;

  localparam int MAX_ELEMENTS  = 12;
  localparam int ELEMENT_SLOTS = 12;
  localparam int ELEM_W        = 4;
  localparam int NUM_VALS      = 1 << ELEM_W;
  localparam int RANK_W        = 29;
  localparam int PERM_W        = ELEMENT_SLOTS * ELEM_W;
  localparam int RECIP_W       = 32;
  localparam int PROD_W        = RANK_W + RECIP_W;
  localparam int TOTAL_W       = RANK_W + 1;
  localparam int SLOT_W        = $clog2(ELEMENT_SLOTS);

  localparam logic [TOTAL_W-1:0] RANK_LIMIT = TOTAL_W'(1) << RANK_W;

  typedef logic [TOTAL_W-1:0] total_t;
  typedef total_t [NUM_VALS-1:0][NUM_VALS-1:0] fall_tbl_t;
  typedef logic [NUM_VALS-1:0][RECIP_W-1:0] recip_tbl_t;

  // n!/(n-k)!, saturated just above the rank limit
  function automatic fall_tbl_t build_fall_tbl();
    fall_tbl_t       t;
    longint unsigned p;
    for (int n = 0; n < NUM_VALS; n++) begin
      for (int k = 0; k < NUM_VALS; k++) begin
        p = 1;
        for (int i = 0; i < k; i++) begin
          if (i < n) begin
            p = p * longint'(n - i);
          end else begin
            p = 0;
          end
          if (p > longint'(RANK_LIMIT)) begin
            p = longint'(RANK_LIMIT) + 1;
          end
        end
        t[n][k] = TOTAL_W'(p);
      end
    end
    return t;
  endfunction

  localparam fall_tbl_t FALL_TBL = build_fall_tbl();

  localparam longint unsigned RECIP_ONE = longint'(1) << RECIP_W;

  // ceil(2^32 / r); radix one bypasses the multiplier
  localparam recip_tbl_t RECIP_TBL = {
    RECIP_W'((RECIP_ONE + 64'd14) / 64'd15),
    RECIP_W'((RECIP_ONE + 64'd13) / 64'd14),
    RECIP_W'((RECIP_ONE + 64'd12) / 64'd13),
    RECIP_W'((RECIP_ONE + 64'd11) / 64'd12),
    RECIP_W'((RECIP_ONE + 64'd10) / 64'd11),
    RECIP_W'((RECIP_ONE + 64'd9) / 64'd10),
    RECIP_W'((RECIP_ONE + 64'd8) / 64'd9),
    RECIP_W'((RECIP_ONE + 64'd7) / 64'd8),
    RECIP_W'((RECIP_ONE + 64'd6) / 64'd7),
    RECIP_W'((RECIP_ONE + 64'd5) / 64'd6),
    RECIP_W'((RECIP_ONE + 64'd4) / 64'd5),
    RECIP_W'((RECIP_ONE + 64'd3) / 64'd4),
    RECIP_W'((RECIP_ONE + 64'd2) / 64'd3),
    RECIP_W'((RECIP_ONE + 64'd1) / 64'd2),
    RECIP_W'(0),
    RECIP_W'(0)
  };

endpackage

// ----- hdl/ppru_if.sv -----
// request and response channel interfaces of the partial permutation rank unit
interface ppru_req_if import ppru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ELEM_W-1:0] total_count;
  logic [ELEM_W-1:0] chosen_count;
  logic [RANK_W-1:0] rank_in;
  logic [PERM_W-1:0] perm_in;

  modport source (
    output valid, operation, total_count, chosen_count, rank_in, perm_in,
    input  ready
  );
  modport sink (
    input  valid, operation, total_count, chosen_count, rank_in, perm_in,
    output ready
  );
endinterface

interface ppru_rsp_if import ppru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank_out;
  logic [PERM_W-1:0] perm_out;
  logic              error;

  modport source (
    output valid, rank_out, perm_out, error,
    input  ready
  );
  modport sink (
    input  valid, rank_out, perm_out, error,
    output ready
  );
endinterface

// ----- hdl/partial_permutation_rank_unrank_unit.sv -----
// top level: sequencer for lehmer rank and unrank of partial permutations
// rank passes S_RANK per element (a bad element ends it early), unrank S_DIV_MUL and S_DIV_FIX
// per digit then S_PICK per element, a rejected or empty request goes straight to S_FINISH;
// one request is worked at a time, the next is taken once S_FINISH has loaded the response
// rank folds one digit per cycle through the shared multiplier; unrank spends two multiplier
// passes per digit (reciprocal, remainder fix) and one free-value select step per element
// asynchronous active-low reset returns the sequencer to idle and drops response valid
module partial_permutation_rank_unrank_unit import ppru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppru_req_if.sink    req_i,
  ppru_rsp_if.source  rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANK,
    S_DIV_MUL,
    S_DIV_FIX,
    S_PICK,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  logic                op_q, op_d;
  logic                err_q, err_d;
  logic [ELEM_W-1:0]   n_q, n_d;
  logic [ELEM_W-1:0]   k_q, k_d;
  logic [PERM_W-1:0]   perm_q, perm_d;
  logic [RANK_W-1:0]   x_q, x_d;
  logic [RANK_W-1:0]   q_q, q_d;
  logic [SLOT_W-1:0]   i_q, i_d;
  logic [NUM_VALS-1:0] used_q, used_d;
  logic [ELEM_W-1:0]   digit_q [ELEMENT_SLOTS];
  logic [ELEM_W-1:0]   digit_d [ELEMENT_SLOTS];
  logic [PERM_W-1:0]   pacc_q, pacc_d;
  logic [RANK_W-1:0]   rank_out_q, rank_out_d;
  logic [PERM_W-1:0]   perm_out_q, perm_out_d;
  logic                error_q, error_d;

  logic [RANK_W-1:0]  mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic [ELEM_W-1:0]  radix;
  logic [ELEM_W-1:0]  elem;
  logic [ELEM_W-1:0]  below;
  logic [ELEM_W-1:0]  pick;
  logic [ELEM_W-1:0]  skip;
  logic [ELEM_W-1:0]  rank_digit;
  logic               elem_bad;
  logic               last;
  logic [TOTAL_W-1:0] diff;
  logic               diff_neg;
  logic [ELEM_W-1:0]  rem_digit;
  logic [SLOT_W-1:0]  dix;
  total_t             total;
  logic               chk_err;

  ppru_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  ppru_lehmer u_lehmer (
    .used_i  (used_q),
    .value_i (elem),
    .skip_i  (skip),
    .below_o (below),
    .pick_o  (pick)
  );

  assign radix      = n_q - k_q + ELEM_W'(i_q) + ELEM_W'(1);
  assign elem       = perm_q[ELEM_W*i_q +: ELEM_W];
  assign skip       = digit_q[i_q];
  assign rank_digit = elem - below;
  assign elem_bad   = (elem >= n_q) || used_q[elem];
  assign last       = (ELEM_W'(i_q) == k_q - ELEM_W'(1));
  assign diff       = {1'b0, x_q} - mul_p[TOTAL_W-1:0];
  assign diff_neg   = diff[TOTAL_W-1];
  assign rem_digit  = ELEM_W'(diff) + (diff_neg ? radix : ELEM_W'(0));
  assign dix        = SLOT_W'(k_q - ELEM_W'(1) - ELEM_W'(i_q));

  assign total   = FALL_TBL[req_i.total_count][req_i.chosen_count];
  assign chk_err = (int'(req_i.total_count) > MAX_ELEMENTS)
                || (int'(req_i.chosen_count) > ELEMENT_SLOTS)
                || (req_i.chosen_count > req_i.total_count)
                || (total > RANK_LIMIT)
                || (req_i.operation && ({1'b0, req_i.rank_in} >= total));

  always_comb begin
    case (state_q)
      S_RANK: begin
        mul_a = x_q;
        mul_b = RECIP_W'(n_q - ELEM_W'(i_q));
      end
      S_DIV_MUL: begin
        mul_a = x_q;
        mul_b = RECIP_TBL[radix];
      end
      default: begin
        mul_a = q_q;
        mul_b = RECIP_W'(radix);
      end
    endcase
  end

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.rank_out = rank_out_q;
  assign rsp_o.perm_out = perm_out_q;
  assign rsp_o.error    = error_q;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    op_d        = op_q;
    err_d       = err_q;
    n_d         = n_q;
    k_d         = k_q;
    perm_d      = perm_q;
    x_d         = x_q;
    q_d         = q_q;
    i_d         = i_q;
    used_d      = used_q;
    digit_d     = digit_q;
    pacc_d      = pacc_q;
    rank_out_d  = rank_out_q;
    perm_out_d  = perm_out_q;
    error_d     = error_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d   = req_i.operation;
          n_d    = req_i.total_count;
          k_d    = req_i.chosen_count;
          perm_d = req_i.perm_in;
          x_d    = req_i.operation ? req_i.rank_in : '0;
          err_d  = chk_err;
          i_d    = '0;
          used_d = '0;
          pacc_d = '0;
          if (chk_err || (req_i.chosen_count == '0)) begin
            state_d = S_FINISH;
          end else if (req_i.operation) begin
            state_d = S_DIV_MUL;
          end else begin
            state_d = S_RANK;
          end
        end
      end
      S_RANK: begin
        if (elem_bad) begin
          err_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          x_d    = RANK_W'(mul_p) + RANK_W'(rank_digit);
          used_d = used_q | (NUM_VALS'(1) << elem);
          i_d    = i_q + SLOT_W'(1);
          if (last) begin
            state_d = S_FINISH;
          end
        end
      end
      S_DIV_MUL: begin
        q_d     = (radix == ELEM_W'(1)) ? x_q : mul_p[PROD_W-1:RECIP_W];
        state_d = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        digit_d[dix] = rem_digit;
        x_d          = diff_neg ? (q_q - RANK_W'(1)) : q_q;
        if (last) begin
          i_d     = '0;
          used_d  = '0;
          state_d = S_PICK;
        end else begin
          i_d     = i_q + SLOT_W'(1);
          state_d = S_DIV_MUL;
        end
      end
      S_PICK: begin
        pacc_d[ELEM_W*i_q +: ELEM_W] = pick;
        used_d = used_q | (NUM_VALS'(1) << pick);
        i_d    = i_q + SLOT_W'(1);
        if (last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rank_out_d  = (!err_q && !op_q) ? x_q : '0;
          perm_out_d  = (!err_q && op_q) ? pacc_q : '0;
          error_d     = err_q;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      op_q        <= 1'b0;
      err_q       <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      perm_q      <= '0;
      x_q         <= '0;
      q_q         <= '0;
      i_q         <= '0;
      used_q      <= '0;
      digit_q     <= '{default: '0};
      pacc_q      <= '0;
      rank_out_q  <= '0;
      perm_out_q  <= '0;
      error_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      op_q        <= op_d;
      err_q       <= err_d;
      n_q         <= n_d;
      k_q         <= k_d;
      perm_q      <= perm_d;
      x_q         <= x_d;
      q_q         <= q_d;
      i_q         <= i_d;
      used_q      <= used_d;
      digit_q     <= digit_d;
      pacc_q      <= pacc_d;
      rank_out_q  <= rank_out_d;
      perm_out_q  <= perm_out_d;
      error_q     <= error_d;
    end
  end

endmodule

// ----- hdl/ppru_mul.sv -----
// shared multiplier of the rank unit: fold, reciprocal and remainder products
module ppru_mul import ppru_pkg::*; (
  input  logic [RANK_W-1:0]  a_i,
  input  logic [RECIP_W-1:0] b_i,
  output logic [PROD_W-1:0]  p_o
);

  assign p_o = PROD_W'(a_i) * PROD_W'(b_i);

endmodule

// ----- hdl/ppru_lehmer.sv -----
// lehmer digit helpers: masked popcount of used values and select of nth free value
module ppru_lehmer import ppru_pkg::*; (
  input  logic [NUM_VALS-1:0] used_i,
  input  logic [ELEM_W-1:0]   value_i,
  input  logic [ELEM_W-1:0]   skip_i,
  output logic [ELEM_W-1:0]   below_o,
  output logic [ELEM_W-1:0]   pick_o
);

  logic [NUM_VALS-1:0] below_mask;

  assign below_mask = (NUM_VALS'(1) << value_i) - NUM_VALS'(1);
  assign below_o    = ELEM_W'($countones(used_i & below_mask));

  always_comb begin
    logic [NUM_VALS-1:0] lane_mask;
    pick_o = '0;
    for (int v = 0; v < NUM_VALS; v++) begin
      lane_mask = (NUM_VALS'(1) << v) - NUM_VALS'(1);
      if (!used_i[v] && (ELEM_W'($countones(~used_i & lane_mask)) == skip_i)) begin
        pick_o = pick_o | ELEM_W'(v);
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the lehmer rank and unrank unit
`timescale 1ns / 100ps

module testbench import ppru_pkg::*; ();

  typedef enum logic {
    OP_RANK   = 1'b0,
    OP_UNRANK = 1'b1
  } lehmer_op_e;

  typedef struct {
    lehmer_op_e        op;
    logic [ELEM_W-1:0] n;
    logic [ELEM_W-1:0] k;
    logic [RANK_W-1:0] idx;
    logic [PERM_W-1:0] sel;
    bit                drain;
  } lehmer_req_t;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [PERM_W-1:0] sel;
    logic              err;
  } lehmer_rsp_t;

  localparam longint unsigned RANK_SPAN  = longint'(1) << RANK_W;
  localparam int              DRAIN_WAIT = 3 * ELEMENT_SLOTS + 8;

  logic clk_i;
  logic rst_ni;

  ppru_req_if req_if ();
  ppru_rsp_if rsp_if ();

  partial_permutation_rank_unrank_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lehmer_req_t request_q[$];
  lehmer_rsp_t expected_q[$];
  lehmer_req_t active_req;
  int unsigned mismatch_count = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  bit          send_burst     = 1'b0;
  bit          recv_burst     = 1'b0;

  task automatic queue_request(lehmer_req_t r);
    request_q = {request_q, r};
  endtask

  task automatic queue_expected(lehmer_rsp_t e);
    expected_q = {expected_q, e};
  endtask

  // n!/(n-k)!
  function automatic longint unsigned arrangement_count(int unsigned n, int unsigned k);
    longint unsigned c;
    c = 1;
    for (int unsigned i = 0; i < k; i++) begin
      c = c * longint'(n - i);
    end
    return c;
  endfunction

  function automatic lehmer_rsp_t predict_lehmer(lehmer_req_t r);
    lehmer_rsp_t          res;
    longint unsigned      cnt;
    longint unsigned      code;
    longint unsigned      rem;
    int unsigned          n;
    int unsigned          k;
    int unsigned          v;
    int unsigned          skip;
    int unsigned          pick;
    int unsigned          digit [ELEMENT_SLOTS];
    logic [NUM_VALS-1:0]  taken;
    bit                   bad;
    bit                   found;
    res   = '{default: '0};
    n     = r.n;
    k     = r.k;
    taken = '0;
    bad   = 1'b0;
    code  = 0;
    if (n > MAX_ELEMENTS || k > n || k > ELEMENT_SLOTS) begin
      res.err = 1'b1;
      return res;
    end
    cnt = arrangement_count(n, k);
    if (cnt > RANK_SPAN) begin
      res.err = 1'b1;
      return res;
    end
    if (r.op == OP_RANK) begin
      for (int unsigned i = 0; i < k; i++) begin
        v = r.sel[ELEM_W*i +: ELEM_W];
        if (!bad) begin
          if (v >= n || taken[v]) begin
            bad = 1'b1;
          end else begin
            code = code * longint'(n - i)
                 + longint'(v - $countones(taken & ((16'd1 << v) - 16'd1)));
            taken[v] = 1'b1;
          end
        end
      end
      res.rank = RANK_W'(code);
    end else if (longint'(r.idx) >= cnt) begin
      bad = 1'b1;
    end else begin
      rem = r.idx;
      for (int unsigned i = 0; i < k; i++) begin
        digit[k-1-i] = int'(rem % longint'(n - k + i + 1));
        rem = rem / longint'(n - k + i + 1);
      end
      for (int unsigned i = 0; i < k; i++) begin
        skip  = digit[i];
        pick  = 0;
        found = 1'b0;
        for (int unsigned u = 0; u < n; u++) begin
          if (!found && !taken[u]) begin
            if (skip == 0) begin
              pick  = u;
              found = 1'b1;
            end else begin
              skip--;
            end
          end
        end
        taken[pick] = 1'b1;
        res.sel[ELEM_W*i +: ELEM_W] = ELEM_W'(pick);
      end
    end
    if (bad) begin
      res = '{default: '0};
      res.err = 1'b1;
    end
    return res;
  endfunction

  function automatic lehmer_req_t make_req(lehmer_op_e op, int unsigned n, int unsigned k,
                                           logic [RANK_W-1:0] idx, logic [PERM_W-1:0] sel);
    lehmer_req_t r;
    r.op    = op;
    r.n     = ELEM_W'(n);
    r.k     = ELEM_W'(k);
    r.idx   = idx;
    r.sel   = sel;
    r.drain = 1'b0;
    return r;
  endfunction

  always #2 clk_i = ~clk_i;

  initial begin
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.operation    = OP_RANK;
    req_if.total_count  = '0;
    req_if.chosen_count = '0;
    req_if.rank_in      = '0;
    req_if.perm_in      = '0;
    rsp_if.ready        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    lehmer_req_t nxt;
    bit          load;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      load = 1'b0;
      if (req_if.valid && req_if.ready) begin
        queue_expected(predict_lehmer(active_req));
        send_gap = send_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0) begin
          send_burst = !send_burst;
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain && expected_q.size() > 0)) begin
          nxt        = request_q.pop_front();
          active_req = nxt;
          load       = 1'b1;
        end
        if (load) begin
          req_if.valid        <= 1'b1;
          req_if.operation    <= nxt.op;
          req_if.total_count  <= nxt.n;
          req_if.chosen_count <= nxt.k;
          req_if.rank_in      <= nxt.idx;
          req_if.perm_in      <= nxt.sel;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin : response_monitor
    lehmer_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("response beat with no request pending");
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_if.rank_out !== want.rank) begin
            $error("rank_out: expected %0d, got %0d", want.rank, rsp_if.rank_out);
            mismatch_count++;
          end
          if (rsp_if.perm_out !== want.sel) begin
            $error("perm_out: expected %h, got %h", want.sel, rsp_if.perm_out);
            mismatch_count++;
          end
          if (rsp_if.error !== want.err) begin
            $error("error: expected %b, got %b", want.err, rsp_if.error);
            mismatch_count++;
          end
        end
        recv_gap = recv_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0) begin
          recv_burst = !recv_burst;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    lehmer_req_t     r;
    int unsigned     pool [MAX_ELEMENTS];
    int unsigned     n;
    int unsigned     k;
    int unsigned     j;
    int unsigned     a;
    int unsigned     b;
    int unsigned     tmp;
    int unsigned     kind;
    longint unsigned cnt;

    // directed
    queue_request(make_req(OP_RANK, 1, 1, '0, '0));
    queue_request(make_req(OP_RANK, 12, 12, '1, 48'hBA9876543210));
    queue_request(make_req(OP_RANK, 12, 12, '0, 48'h0123456789AB));
    queue_request(make_req(OP_UNRANK, 12, 12, '0, '1));
    queue_request(make_req(OP_UNRANK, 12, 12, 29'd479001599, '0));
    queue_request(make_req(OP_RANK, 5, 0, '1, '1));
    queue_request(make_req(OP_RANK, 0, 0, '0, '0));
    queue_request(make_req(OP_UNRANK, 0, 0, '0, '0));
    queue_request(make_req(OP_UNRANK, 3, 0, 29'd1, '0));
    queue_request(make_req(OP_RANK, 13, 1, '0, '0));
    queue_request(make_req(OP_UNRANK, 15, 15, '0, '0));
    queue_request(make_req(OP_RANK, 3, 4, '0, 48'h0210));
    queue_request(make_req(OP_UNRANK, 12, 13, '0, '0));
    queue_request(make_req(OP_RANK, 5, 3, '0, 48'h170));
    queue_request(make_req(OP_RANK, 6, 3, '0, 48'h242));
    queue_request(make_req(OP_RANK, 12, 12, '0, '1));
    queue_request(make_req(OP_UNRANK, 5, 2, 29'd20, '0));
    queue_request(make_req(OP_UNRANK, 5, 2, 29'd19, '0));
    queue_request(make_req(OP_UNRANK, 12, 12, '1, '0));
    queue_request(make_req(OP_UNRANK, 12, 1, 29'd11, '0));
    queue_request(make_req(OP_RANK, 12, 1, '0, 48'hFFFFFFFFFFFB));
    queue_request(make_req(OP_UNRANK, 12, 6, 29'd665279, '0));
    queue_request(make_req(OP_RANK, 12, 6, '0, 48'h6789AB));

    // random
    for (int i = 0; i < 1150; i++) begin
      r.op    = lehmer_op_e'($urandom_range(0, 1));
      r.idx   = RANK_W'($urandom);
      r.sel   = PERM_W'({$urandom, $urandom});
      r.drain = (i % 300 == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 85) begin
        // well-formed selection or index, optionally broken afterwards
        n = (kind >= 78) ? $urandom_range(2, 12) : $urandom_range(1, 12);
        k = (kind >= 70) ? $urandom_range(2, n) : $urandom_range(0, n);
        for (int unsigned u = 0; u < n; u++) begin
          pool[u] = u;
        end
        for (int unsigned u = 0; u < k; u++) begin
          j       = $urandom_range(u, n - 1);
          tmp     = pool[u];
          pool[u] = pool[j];
          pool[j] = tmp;
          r.sel[ELEM_W*u +: ELEM_W] = ELEM_W'(pool[u]);
        end
        cnt   = arrangement_count(n, k);
        r.n   = ELEM_W'(n);
        r.k   = ELEM_W'(k);
        r.idx = RANK_W'($urandom_range(0, 32'(cnt - 1)));
        if (kind >= 78) begin
          a = $urandom_range(0, k - 1);
          if (r.op == OP_RANK) begin
            b = (a + $urandom_range(1, k - 1)) % k;
            r.sel[ELEM_W*b +: ELEM_W] = r.sel[ELEM_W*a +: ELEM_W];
          end else begin
            r.idx = RANK_W'(cnt + $urandom_range(0, 32'(RANK_SPAN - 1 - cnt)));
          end
        end else if (kind >= 70) begin
          a = $urandom_range(0, k - 1);
          r.sel[ELEM_W*a +: ELEM_W] = ELEM_W'($urandom_range(n, NUM_VALS - 1));
          if (r.op == OP_UNRANK) begin
            r.idx = RANK_W'(cnt + $urandom_range(0, 32'(RANK_SPAN - 1 - cnt)));
          end
        end
      end else if (kind < 90) begin
        n   = $urandom_range(0, 11);
        r.n = ELEM_W'(n);
        r.k = ELEM_W'($urandom_range(n + 1, NUM_VALS - 1));
      end else if (kind < 93) begin
        r.n = ELEM_W'($urandom_range(MAX_ELEMENTS + 1, NUM_VALS - 1));
        r.k = ELEM_W'($urandom);
      end else begin
        r.n = ELEM_W'($urandom);
        r.k = ELEM_W'($urandom);
      end
      queue_request(r);
    end

    @(posedge rst_ni);
    while (request_q.size() > 0 || req_if.valid) begin
      @(posedge clk_i);
    end
    while (expected_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
